/* src/polynomial_evaluator_macros.svh */
// Assertion macros shared by the polynomial evaluator RTL.
`ifndef POLYNOMIAL_EVALUATOR_MACROS_SVH
`define POLYNOMIAL_EVALUATOR_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clk_i edge outside reset.
`define PE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define PE_ASSERT_NEVER(lbl, cond, msg) \
  `PE_ASSERT(lbl, !(cond), msg)
`else
`define PE_ASSERT(lbl, prop, msg)
`define PE_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* src/poly_eval_pkg.sv */
// Shared types and constants of the polynomial evaluator.
package poly_eval_pkg;

  // Coefficient table and field widths
  localparam int MAX_DEGREE = 15;
  localparam int COEF_DEPTH = MAX_DEGREE + 1;
  localparam int DEG_W      = 4;
  localparam int COEF_W     = 16;
  localparam int X_W        = 16;
  localparam int VALUE_W    = 64;
  localparam int HALF_W     = VALUE_W / 2;
  localparam int MUL_A_W    = HALF_W + 1;
  localparam int MUL_P_W    = MUL_A_W + X_W;
  localparam int PROD_W     = MUL_P_W + HALF_W;
  localparam int SUM_W      = VALUE_W + 1;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_DEGREE = 1'b0;

  // Saturation limits
  localparam logic [VALUE_W-1:0] SAT_POS = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] SAT_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LO   = 5'b00010,
    ST_HI   = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

endpackage

/* src/polynomial_evaluator.sv */
// Horner polynomial evaluator with a shared 33x16 multiplier and saturation.
//
// Input channel (in_valid_i / in_stall_o) carries command_i, coef_index_i,
// coef_value_i and x_i. A write beat stores coef_value_i into slot
// coef_index_i and gives no result. An evaluate beat computes
// the polynomial of degree "degree" at x_i and gives one result beat of
// value_o and overflow_o on the output channel (out_valid_o / out_stall_i).
// Each Horner step runs on one shared multiplier in turn: low half of
// the accumulator times x, high half times x with recombination, then the
// coefficient add with range checks. An overflow ends the run early.
// in_stall_o is high during evaluation.
// The result sits in an output register, so new beats are accepted while it
// waits; if the receiver still stalls when the next result is ready, the
// evaluator holds it and stalls its input until the register frees.
// Reset clears the coefficient table to zero, degree to zero and drops any
// pending result. degree is written over the APB port at addresses 0 to 3 (paddr[2] clear).
module polynomial_evaluator
  import poly_eval_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic [DEG_W-1:0]          coef_index_i,
  input  logic signed [COEF_W-1:0]  coef_value_i,
  input  logic signed [X_W-1:0]     x_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                      overflow_o,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

`include "polynomial_evaluator_macros.svh"

  state_e                     state_q, state_d;
  logic [DEG_W-1:0]           degree_q;
  logic signed [COEF_W-1:0]   coef_q [COEF_DEPTH];
  logic [DEG_W-1:0]           idx_q, idx_d;
  logic signed [X_W-1:0]      x_q;
  logic [VALUE_W-1:0]         acc_q, acc_d;
  logic                       ovf_q, ovf_d;
  logic signed [MUL_P_W-1:0]  prod_lo_q;
  logic [PROD_W-1:0]          prod_q;
  logic                       out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]         value_q, value_d;
  logic                       overflow_q, overflow_d;

  logic                       in_accept;
  logic                       cfg_write;
  logic                       out_free;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic [COEF_W-1:0]          coef_rd;
  logic [SUM_W-1:0]           sum;
  logic                       prod_fits;
  logic                       sum_ovf;
  logic                       step_ovf;
  logic [VALUE_W-1:0]         step_val;
  logic                       finish;

  // Handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign overflow_o  = overflow_q;

  // Configuration register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_DEGREE);
  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_DEGREE) begin
      prdata = {{(PDATA_W-DEG_W){1'b0}}, degree_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
    end else if (cfg_write) begin
      degree_q <= pwdata[DEG_W-1:0];
    end
  end

  // Coefficient table, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COEF_DEPTH; i++) begin
        coef_q[i] <= '0;
      end
    end else if (in_accept && (command_i == CMD_WRITE)) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // Shared multiplier: low half (unsigned) or high half (signed) times x
  always_comb begin
    if (state_q == ST_HI) begin
      mul_a = {acc_q[VALUE_W-1], acc_q[VALUE_W-1:HALF_W]};
    end else begin
      mul_a = {1'b0, acc_q[HALF_W-1:0]};
    end
  end
  assign mul_p = mul_a * x_q;

  // Coefficient add and range checks
  assign coef_rd   = coef_q[idx_q];
  assign sum       = {prod_q[VALUE_W-1], prod_q[VALUE_W-1:0]}
                   + {{(SUM_W-COEF_W){coef_rd[COEF_W-1]}}, coef_rd};
  assign prod_fits = (&prod_q[PROD_W-1:VALUE_W-1]) || !(|prod_q[PROD_W-1:VALUE_W-1]);
  assign sum_ovf   = sum[SUM_W-1] ^ sum[SUM_W-2];
  assign step_ovf  = !prod_fits || sum_ovf;
  always_comb begin
    if (!prod_fits) begin
      step_val = prod_q[PROD_W-1] ? SAT_NEG : SAT_POS;
    end else if (sum_ovf) begin
      step_val = sum[SUM_W-1] ? SAT_NEG : SAT_POS;
    end else begin
      step_val = sum[VALUE_W-1:0];
    end
  end
  assign finish = step_ovf || (idx_q == degree_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    value_d     = value_q;
    overflow_d  = overflow_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (command_i == CMD_EVAL)) begin
          idx_d   = '0;
          acc_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_LO;
        end
      end
      ST_LO: begin
        state_d = ST_HI;
      end
      ST_HI: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (finish) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            value_d     = step_val;
            overflow_d  = step_ovf;
            state_d     = ST_IDLE;
          end else begin
            acc_d   = step_val;
            ovf_d   = step_ovf;
            state_d = ST_DONE;
          end
        end else begin
          acc_d   = step_val;
          idx_d   = idx_q + 1'b1;
          state_d = ST_LO;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          value_d     = acc_q;
          overflow_d  = ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    ovf_q      <= ovf_d;
    value_q    <= value_d;
    overflow_q <= overflow_d;
    if (in_accept) begin
      x_q <= x_i;
    end
    if (state_q == ST_LO) begin
      prod_lo_q <= mul_p;
    end
    if (state_q == ST_HI) begin
      prod_q <= {mul_p, {HALF_W{1'b0}}}
              + {{(PROD_W-MUL_P_W){prod_lo_q[MUL_P_W-1]}}, prod_lo_q};
    end
  end

  // Checks
  `PE_ASSERT(a_idx_in_range, (state_q != ST_IDLE) |-> (idx_q <= degree_q), "index past degree")
  `PE_ASSERT(a_eval_starts, (in_accept && command_i == CMD_EVAL) |=> (state_q == ST_LO), "eval did not start")
  `PE_ASSERT(a_hi_then_add, (state_q == ST_HI) |=> (state_q == ST_ADD), "add phase skipped")
  `PE_ASSERT(a_ovf_saturates, (out_valid_o && overflow_o) |-> (value_o == SAT_POS || value_o == SAT_NEG), "overflow without saturation")
  `PE_ASSERT_NEVER(a_no_done_when_free, (state_q == ST_DONE) && $past(out_free) && $past(state_q == ST_DONE), "held result not released")

endmodule
